[rtl/core/tasi_pkg.sv]
// Shared types and codes for the three-axis step interpolator.
// Holds operation codes, lane control, sequencer status and the result record.
// No dependencies.
package tasi_pkg;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_SET  = 2'd2;
   localparam logic [1:0] OP_NOP  = 2'd3;

   localparam int          AXES            = 3;
   localparam int          POS_BITS        = 32;
   localparam int          PERIOD_BITS     = 16;
   localparam logic [15:0] MIN_PERIOD_RST  = 16'd10;

   typedef struct packed {
      logic load;
      logic advance;
      logic set;
   } tasi_lane_ctrl_type;

   typedef struct packed {
      logic load;
      logic advance;
      logic rejected;
      logic done;
      logic busy;
   } tasi_seq_stat_type;

   typedef struct packed {
      logic                       step_x;
      logic                       step_y;
      logic                       step_z;
      logic                       dir_x;
      logic                       dir_y;
      logic                       dir_z;
      logic                       busy_res;
      logic                       move_done;
      logic                       rejected;
      logic signed [POS_BITS-1:0] pos_x;
      logic signed [POS_BITS-1:0] pos_y;
      logic signed [POS_BITS-1:0] pos_z;
   } tasi_rsp_type;

endpackage

[rtl/core/tasi_lane.sv]
// One axis lane: delta, Bresenham error accumulator and position.
// Depends on tasi_pkg.
module tasi_lane #(
   parameter int DELTA_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tasi_pkg::tasi_lane_ctrl_type       ctrl,
   input  logic signed [DELTA_BITS-1:0]       delta,
   input  logic        [DELTA_BITS-1:0]       major,
   output logic                               stepped,
   output logic                               dir,
   output logic signed [tasi_pkg::POS_BITS-1:0] position
);
   import tasi_pkg::*;

   localparam int ERR_BITS = DELTA_BITS + 2;

   logic signed [DELTA_BITS-1:0] delta_ff, delta_in;
   logic signed [ERR_BITS-1:0]   error_ff, error_in;
   logic signed [POS_BITS-1:0]   position_ff, position_in;
   logic signed [ERR_BITS-1:0]   sum;
   logic signed [ERR_BITS-1:0]   maj_pos;
   logic signed [ERR_BITS-1:0]   maj_neg;

   always_comb begin
      sum         = error_ff + $signed({{2{delta_ff[DELTA_BITS-1]}}, delta_ff});
      maj_pos     = $signed({2'b00, major});
      maj_neg     = -maj_pos;
      delta_in    = delta_ff;
      error_in    = error_ff;
      position_in = position_ff;
      stepped     = 1'b0;
      if (ctrl.load) begin
         delta_in = delta;
         error_in = '0;
      end
      if (ctrl.advance) begin
         if (sum >= maj_pos) begin
            error_in    = sum - maj_pos;
            position_in = position_ff + 32'sd1;
            stepped     = 1'b1;
         end else if (sum <= maj_neg) begin
            error_in    = sum + maj_pos;
            position_in = position_ff - 32'sd1;
            stepped     = 1'b1;
         end else begin
            error_in = sum;
         end
      end
      if (ctrl.set) begin
         position_in = $signed({{(POS_BITS-DELTA_BITS){delta[DELTA_BITS-1]}}, delta});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff    <= '0;
         error_ff    <= '0;
         position_ff <= '0;
      end else begin
         delta_ff    <= delta_in;
         error_ff    <= error_in;
         position_ff <= position_in;
      end
   end

   assign dir      = ~delta_in[DELTA_BITS-1];
   assign position = position_in;

endmodule

[rtl/core/tasi_seq.sv]
// Move sequencer and lane merge: major count, period counter, step count, busy.
// Depends on tasi_pkg.
module tasi_seq #(
   parameter int DELTA_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [1:0]                            operation,
   input  logic signed [DELTA_BITS-1:0]          delta_x,
   input  logic signed [DELTA_BITS-1:0]          delta_y,
   input  logic signed [DELTA_BITS-1:0]          delta_z,
   input  logic [tasi_pkg::PERIOD_BITS-1:0]      step_period,
   input  logic [tasi_pkg::PERIOD_BITS-1:0]      min_period,
   output tasi_pkg::tasi_seq_stat_type           stat,
   output logic [DELTA_BITS-1:0]                 major
);
   import tasi_pkg::*;

   logic                   moving_ff, moving_in;
   logic [DELTA_BITS-1:0]  major_ff, major_in;
   logic [DELTA_BITS-1:0]  steps_ff, steps_in;
   logic [PERIOD_BITS-1:0] tick_ff, tick_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [DELTA_BITS-1:0]  abs_x, abs_y, abs_z, abs_max;
   logic [DELTA_BITS:0]    steps_inc;
   logic [PERIOD_BITS:0]   tick_inc;
   logic [PERIOD_BITS-1:0] period_sel;
   logic                   tick_op;

   always_comb begin
      abs_x   = delta_x[DELTA_BITS-1] ? DELTA_BITS'(-delta_x) : DELTA_BITS'(delta_x);
      abs_y   = delta_y[DELTA_BITS-1] ? DELTA_BITS'(-delta_y) : DELTA_BITS'(delta_y);
      abs_z   = delta_z[DELTA_BITS-1] ? DELTA_BITS'(-delta_z) : DELTA_BITS'(delta_z);
      abs_max = abs_x;
      if (abs_y > abs_max) begin
         abs_max = abs_y;
      end
      if (abs_z > abs_max) begin
         abs_max = abs_z;
      end

      period_sel = (step_period < min_period) ? min_period : step_period;
      if (period_sel == '0) begin
         period_sel = {{(PERIOD_BITS-1){1'b0}}, 1'b1};
      end

      stat          = '0;
      stat.load     = accept && (operation == OP_LOAD) && !moving_ff;
      stat.rejected = accept && (operation == OP_LOAD) && moving_ff;
      tick_op       = accept && (operation == OP_TICK) && moving_ff;
      stat.advance  = tick_op && (tick_ff == '0);

      steps_inc = {1'b0, steps_ff} + {{DELTA_BITS{1'b0}}, 1'b1};
      tick_inc  = {1'b0, tick_ff} + {{PERIOD_BITS{1'b0}}, 1'b1};

      moving_in = moving_ff;
      major_in  = major_ff;
      steps_in  = steps_ff;
      tick_in   = tick_ff;
      period_in = period_ff;

      if (stat.load) begin
         major_in  = abs_max;
         steps_in  = '0;
         tick_in   = '0;
         period_in = period_sel;
         moving_in = (abs_max != '0);
      end
      if (stat.advance) begin
         steps_in = steps_inc[DELTA_BITS-1:0];
         if (steps_inc >= {1'b0, major_ff}) begin
            moving_in = 1'b0;
            stat.done = 1'b1;
         end
      end
      if (tick_op) begin
         tick_in = (tick_inc >= {1'b0, period_ff}) ? '0 : tick_inc[PERIOD_BITS-1:0];
      end
      stat.busy = moving_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff <= 1'b0;
         major_ff  <= '0;
         steps_ff  <= '0;
         tick_ff   <= '0;
         period_ff <= '0;
      end else begin
         moving_ff <= moving_in;
         major_ff  <= major_in;
         steps_ff  <= steps_in;
         tick_ff   <= tick_in;
         period_ff <= period_in;
      end
   end

   assign major = major_ff;

endmodule

[rtl/core/tasi_skid.sv]
// Two-entry output buffer: result register plus skid register.
// Depends on tasi_pkg.
module tasi_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tasi_pkg::tasi_rsp_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tasi_pkg::tasi_rsp_type out_data
);
   import tasi_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   tasi_rsp_type out_data_ff, out_data_in;
   tasi_rsp_type skid_data_ff, skid_data_in;
   logic         out_free;
   logic         take;

   always_comb begin
      in_ready      = ~skid_valid_ff;
      take          = in_valid && in_ready;
      out_free      = ~out_valid_ff || out_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = in_data;
            out_valid_in = take;
         end
      end else if (take) begin
         skid_data_in  = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

[rtl/core/three_axis_step_interpolator.sv]
// Response path: each accepted req transaction is registered in the output register, or in the
// skid register while rsp is stalled. Throughput: one transaction per cycle while req_ready
// is high (it is low while the skid register is full); the per-axis error add and compare
// against the major count, in parallel lanes, sets the cycle. Reset: synchronous, active high;
// clears move state and positions, min_step_period returns to 10. Depends on tasi_pkg, tasi_lane, tasi_seq, tasi_skid.
module three_axis_step_interpolator #(
   parameter int DELTA_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic signed [DELTA_BITS-1:0]         req_delta_x,
   input  logic signed [DELTA_BITS-1:0]         req_delta_y,
   input  logic signed [DELTA_BITS-1:0]         req_delta_z,
   input  logic [2:0]                           req_set_mask,
   input  logic [tasi_pkg::PERIOD_BITS-1:0]     req_step_period,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_step_x,
   output logic                                 rsp_step_y,
   output logic                                 rsp_step_z,
   output logic                                 rsp_dir_x,
   output logic                                 rsp_dir_y,
   output logic                                 rsp_dir_z,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_move_done,
   output logic                                 rsp_rejected,
   output logic signed [tasi_pkg::POS_BITS-1:0] rsp_pos_x,
   output logic signed [tasi_pkg::POS_BITS-1:0] rsp_pos_y,
   output logic signed [tasi_pkg::POS_BITS-1:0] rsp_pos_z,
   input  logic                                 csr_wr_en,
   input  logic [tasi_pkg::PERIOD_BITS-1:0]     csr_wr_data
);
   import tasi_pkg::*;

   logic [PERIOD_BITS-1:0]       min_period_ff, min_period_in;
   logic                         accept;
   tasi_seq_stat_type            stat;
   logic [DELTA_BITS-1:0]        major;
   logic signed [DELTA_BITS-1:0] lane_delta [AXES];
   tasi_lane_ctrl_type           lane_ctrl  [AXES];
   logic [AXES-1:0]              lane_step;
   logic [AXES-1:0]              lane_dir;
   logic signed [POS_BITS-1:0]   lane_pos   [AXES];
   logic                         set_op;
   tasi_rsp_type                 rsp_in;
   tasi_rsp_type                 rsp_out;

   assign accept        = req_valid && req_ready;
   assign set_op        = accept && (req_operation == OP_SET);
   assign min_period_in = csr_wr_en ? csr_wr_data : min_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= MIN_PERIOD_RST;
      end else begin
         min_period_ff <= min_period_in;
      end
   end

   tasi_seq #(
      .DELTA_BITS (DELTA_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .delta_x     (req_delta_x),
      .delta_y     (req_delta_y),
      .delta_z     (req_delta_z),
      .step_period (req_step_period),
      .min_period  (min_period_ff),
      .stat        (stat),
      .major       (major)
   );

   assign lane_delta[0] = req_delta_x;
   assign lane_delta[1] = req_delta_y;
   assign lane_delta[2] = req_delta_z;

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      always_comb begin
         lane_ctrl[g].load    = stat.load;
         lane_ctrl[g].advance = stat.advance;
         lane_ctrl[g].set     = set_op && req_set_mask[g];
      end

      tasi_lane #(
         .DELTA_BITS (DELTA_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl[g]),
         .delta    (lane_delta[g]),
         .major    (major),
         .stepped  (lane_step[g]),
         .dir      (lane_dir[g]),
         .position (lane_pos[g])
      );
   end

   always_comb begin
      rsp_in.step_x    = lane_step[0];
      rsp_in.step_y    = lane_step[1];
      rsp_in.step_z    = lane_step[2];
      rsp_in.dir_x     = lane_dir[0];
      rsp_in.dir_y     = lane_dir[1];
      rsp_in.dir_z     = lane_dir[2];
      rsp_in.busy_res  = stat.busy;
      rsp_in.move_done = stat.done;
      rsp_in.rejected  = stat.rejected;
      rsp_in.pos_x     = lane_pos[0];
      rsp_in.pos_y     = lane_pos[1];
      rsp_in.pos_z     = lane_pos[2];
   end

   tasi_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (rsp_in),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_out)
   );

   assign rsp_step_x    = rsp_out.step_x;
   assign rsp_step_y    = rsp_out.step_y;
   assign rsp_step_z    = rsp_out.step_z;
   assign rsp_dir_x     = rsp_out.dir_x;
   assign rsp_dir_y     = rsp_out.dir_y;
   assign rsp_dir_z     = rsp_out.dir_z;
   assign rsp_busy_res  = rsp_out.busy_res;
   assign rsp_move_done = rsp_out.move_done;
   assign rsp_rejected  = rsp_out.rejected;
   assign rsp_pos_x     = rsp_out.pos_x;
   assign rsp_pos_y     = rsp_out.pos_y;
   assign rsp_pos_z     = rsp_out.pos_z;

endmodule

[rtl/core/tasi_checker.sv]
// Port-level checks for the three-axis step interpolator, bound to the top level.
// Depends on three_axis_step_interpolator.
module tasi_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_busy_res,
   input logic rsp_move_done,
   input logic rsp_rejected
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_done |-> !rsp_busy_res)
      else $error("move_done reported while still busy");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res && !rsp_move_done)
      else $error("rejected load without a move in progress");

endmodule

bind three_axis_step_interpolator tasi_checker u_tasi_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_move_done (rsp_move_done),
   .rsp_rejected  (rsp_rejected)
);

[verif/tb_top.sv]
// Testbench for three_axis_step_interpolator: directed and random transactions
// checked against an in-bench Bresenham predictor, one response per request.
// Depends on tasi_pkg and the three_axis_step_interpolator RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tasi_pkg::*;

   localparam int DW = 24;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_operation = OP_NOP;
   logic signed [DW-1:0]        req_delta_x = '0;
   logic signed [DW-1:0]        req_delta_y = '0;
   logic signed [DW-1:0]        req_delta_z = '0;
   logic [2:0]                  req_set_mask = '0;
   logic [PERIOD_BITS-1:0]      req_step_period = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_step_x, rsp_step_y, rsp_step_z;
   logic                        rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic                        rsp_busy_res, rsp_move_done, rsp_rejected;
   logic signed [POS_BITS-1:0]  rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic                        csr_wr_en = 1'b0;
   logic [PERIOD_BITS-1:0]      csr_wr_data = '0;

   // predicted interpolator state
   logic [15:0]   min_period = MIN_PERIOD_RST;
   int            mv_delta [3] = '{0, 0, 0};
   longint        mv_error [3] = '{0, 0, 0};
   logic [31:0]   axis_pos [3] = '{0, 0, 0};
   int unsigned   major_cnt = 0;
   int unsigned   steps_taken = 0;
   int unsigned   tick_cnt = 0;
   int unsigned   period_used = 0;
   bit            move_active = 1'b0;

   tasi_rsp_type  expected_rsp [$];
   tasi_rsp_type  rsp_want;
   int            errors = 0;
   int            items_sent = 0;
   int            idle_pct = 33;

   three_axis_step_interpolator #(.DELTA_BITS(DW)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_delta_x     (req_delta_x),
      .req_delta_y     (req_delta_y),
      .req_delta_z     (req_delta_z),
      .req_set_mask    (req_set_mask),
      .req_step_period (req_step_period),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_step_x      (rsp_step_x),
      .rsp_step_y      (rsp_step_y),
      .rsp_step_z      (rsp_step_z),
      .rsp_dir_x       (rsp_dir_x),
      .rsp_dir_y       (rsp_dir_y),
      .rsp_dir_z       (rsp_dir_z),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_move_done   (rsp_move_done),
      .rsp_rejected    (rsp_rejected),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   function automatic tasi_rsp_type predict_step(logic [1:0] op, logic signed [DW-1:0] dx,
                                                 logic signed [DW-1:0] dy,
                                                 logic signed [DW-1:0] dz,
                                                 logic [2:0] mask, logic [15:0] per);
      tasi_rsp_type r;
      int           d [3];
      int           mag_a;
      int unsigned  mx;
      int unsigned  p;
      longint       mj;
      bit [2:0]     stepped;
      bit           done;
      bit           rej;
      d[0] = dx;
      d[1] = dy;
      d[2] = dz;
      stepped = '0;
      done = 1'b0;
      rej = 1'b0;
      case (op)
         OP_LOAD: begin
            if (move_active) begin
               rej = 1'b1;
            end else begin
               mx = 0;
               for (int a = 0; a < 3; a++) begin
                  mv_delta[a] = d[a];
                  mv_error[a] = 0;
                  mag_a = (d[a] < 0) ? -d[a] : d[a];
                  if (mag_a > mx) mx = mag_a;
               end
               major_cnt = mx;
               steps_taken = 0;
               tick_cnt = 0;
               p = per;
               if (p < min_period) p = min_period;
               if (p == 0) p = 1;
               period_used = p;
               move_active = (mx != 0);
            end
         end
         OP_TICK: begin
            if (move_active) begin
               if (tick_cnt == 0) begin
                  mj = major_cnt;
                  for (int a = 0; a < 3; a++) begin
                     mv_error[a] += mv_delta[a];
                     if (mv_error[a] >= mj) begin
                        mv_error[a] -= mj;
                        axis_pos[a] = axis_pos[a] + 32'd1;
                        stepped[a] = 1'b1;
                     end else if (mv_error[a] <= -mj) begin
                        mv_error[a] += mj;
                        axis_pos[a] = axis_pos[a] - 32'd1;
                        stepped[a] = 1'b1;
                     end
                  end
                  steps_taken++;
                  if (steps_taken >= major_cnt) begin
                     move_active = 1'b0;
                     done = 1'b1;
                  end
               end
               tick_cnt++;
               if (tick_cnt >= period_used) tick_cnt = 0;
            end
         end
         OP_SET: begin
            for (int a = 0; a < 3; a++) begin
               if (mask[a]) axis_pos[a] = d[a];
            end
         end
         default: ;
      endcase
      r.step_x    = stepped[0];
      r.step_y    = stepped[1];
      r.step_z    = stepped[2];
      r.dir_x     = (mv_delta[0] >= 0);
      r.dir_y     = (mv_delta[1] >= 0);
      r.dir_z     = (mv_delta[2] >= 0);
      r.busy_res  = move_active;
      r.move_done = done;
      r.rejected  = rej;
      r.pos_x     = axis_pos[0];
      r.pos_y     = axis_pos[1];
      r.pos_z     = axis_pos[2];
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response transaction with nothing pending", $time);
         end else begin
            rsp_want = expected_rsp.pop_front();
            check_field("step_x", rsp_want.step_x, rsp_step_x);
            check_field("step_y", rsp_want.step_y, rsp_step_y);
            check_field("step_z", rsp_want.step_z, rsp_step_z);
            check_field("dir_x", rsp_want.dir_x, rsp_dir_x);
            check_field("dir_y", rsp_want.dir_y, rsp_dir_y);
            check_field("dir_z", rsp_want.dir_z, rsp_dir_z);
            check_field("busy_res", rsp_want.busy_res, rsp_busy_res);
            check_field("move_done", rsp_want.move_done, rsp_move_done);
            check_field("rejected", rsp_want.rejected, rsp_rejected);
            check_field("pos_x", rsp_want.pos_x, rsp_pos_x);
            check_field("pos_y", rsp_want.pos_y, rsp_pos_y);
            check_field("pos_z", rsp_want.pos_z, rsp_pos_z);
         end
      end
   end

   function automatic logic [DW-1:0] rnd24();
      return DW'($urandom);
   endfunction

   function automatic logic [DW-1:0] small_delta(int mag);
      int v;
      v = int'($urandom_range(0, 2 * mag)) - mag;
      return DW'(v);
   endfunction

   task automatic send_item(logic [1:0] op, logic signed [DW-1:0] dx,
                            logic signed [DW-1:0] dy, logic signed [DW-1:0] dz,
                            logic [2:0] mask, logic [15:0] per);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_delta_x     <= dx;
      req_delta_y     <= dy;
      req_delta_z     <= dz;
      req_set_mask    <= mask;
      req_step_period <= per;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp.push_back(predict_step(op, dx, dy, dz, mask, per));
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_min_period(logic [15:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      min_period = v;
      csr_wr_en <= 1'b0;
   endtask

   task automatic tick_until_idle();
      while (move_active) send_item(OP_TICK, rnd24(), rnd24(), rnd24(), 3'($urandom),
                                    16'($urandom));
   endtask

   task automatic test_idle_items();
      send_item(OP_NOP, '0, '0, '0, 3'd0, 16'd0);
      send_item(OP_TICK, '0, '0, '0, 3'd0, 16'd0);
      send_item(OP_SET, 24'sd5, 24'sd6, 24'sd7, 3'd0, 16'd0);
      send_item(OP_SET, 24'sh7FFFFF, 24'sh800000, -24'sd1, 3'd7, 16'hFFFF);
      send_item(OP_SET, 24'sd0, 24'sd123, -24'sd7, 3'd5, 16'd0);
      send_item(OP_NOP, 24'shFFFFFF, 24'shFFFFFF, 24'shFFFFFF, 3'd7, 16'hFFFF);
   endtask

   task automatic test_zero_move();
      send_item(OP_LOAD, '0, '0, '0, 3'd7, 16'd5);
      send_item(OP_TICK, '0, '0, '0, 3'd0, 16'd0);
   endtask

   task automatic test_basic_move();
      send_item(OP_LOAD, 24'sd3, -24'sd2, 24'sd0, 3'd0, 16'd0);
      tick_until_idle();
   endtask

   task automatic test_busy_items();
      set_min_period(16'd1);
      send_item(OP_LOAD, 24'sd4, -24'sd4, 24'sd2, 3'd0, 16'd2);
      send_item(OP_TICK, '0, '0, '0, 3'd0, 16'd0);
      send_item(OP_LOAD, rnd24(), rnd24(), rnd24(), 3'($urandom), 16'($urandom));
      send_item(OP_SET, 24'sd0, 24'sd1000, 24'sd0, 3'd2, 16'd0);
      send_item(OP_NOP, '0, '0, '0, 3'd0, 16'd0);
      tick_until_idle();
   endtask

   task automatic test_period_zero();
      set_min_period(16'd0);
      send_item(OP_LOAD, 24'sd1, 24'sd2, -24'sd3, 3'd0, 16'd0);
      tick_until_idle();
      send_item(OP_LOAD, -24'sd1, 24'sd0, 24'sd0, 3'd0, 16'hFFFF);
      tick_until_idle();
   endtask

   task automatic test_long_period();
      set_min_period(16'd200);
      idle_pct = 0;
      send_item(OP_LOAD, 24'sd2, -24'sd1, 24'sd1, 3'd0, 16'd7);
      tick_until_idle();
      idle_pct = 33;
   endtask

   task automatic random_item(int mag);
      int sel;
      sel = $urandom_range(99);
      if (sel < 6) begin
         send_item(OP_NOP, rnd24(), rnd24(), rnd24(), 3'($urandom), 16'($urandom));
      end else if (sel < 12) begin
         send_item(OP_SET, rnd24(), rnd24(), rnd24(), 3'($urandom), 16'($urandom));
      end else if (sel < 18 && move_active) begin
         send_item(OP_LOAD, rnd24(), rnd24(), rnd24(), 3'($urandom), 16'($urandom));
      end else if (sel < 22 && !move_active) begin
         send_item(OP_LOAD, small_delta(1), small_delta(1), small_delta(1), 3'($urandom),
                   16'($urandom));
      end else if (sel < 70 && !move_active) begin
         send_item(OP_LOAD, small_delta(mag), small_delta(mag), small_delta(mag),
                   3'($urandom), 16'($urandom_range(0, ($urandom_range(3) == 0) ? 20 : 6)));
      end else begin
         send_item(OP_TICK, rnd24(), rnd24(), rnd24(), 3'($urandom), 16'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      logic [15:0] mins [6] = '{16'd10, 16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2};
      int          mag;
      int          stop_at;
      for (int ph = 0; ph < 6; ph++) begin
         set_min_period((ph == 3) ? 16'($urandom_range(1, 20)) : mins[ph]);
         idle_pct = (ph == 5) ? 0 : 33;
         mag = (min_period > 64) ? 1 : 12;
         stop_at = items_sent + 200;
         while (items_sent < stop_at) random_item(mag);
      end
      idle_pct = 33;
      tick_until_idle();
   endtask

   // leaves a move in progress that cannot finish, so it runs last
   task automatic test_extreme_deltas();
      set_min_period(16'd1);
      send_item(OP_LOAD, 24'sh800000, 24'sh7FFFFF, 24'sd1, 3'd0, 16'd1);
      repeat (20) send_item(OP_TICK, '0, '0, '0, 3'd0, 16'd0);
      send_item(OP_LOAD, rnd24(), rnd24(), rnd24(), 3'($urandom), 16'($urandom));
      send_item(OP_SET, rnd24(), rnd24(), rnd24(), 3'd7, 16'd0);
      send_item(OP_NOP, '0, '0, '0, 3'd0, 16'd0);
      repeat (3) send_item(OP_TICK, '0, '0, '0, 3'd0, 16'd0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_idle_items();
      test_zero_move();
      test_basic_move();
      test_busy_items();
      test_period_zero();
      test_long_period();
      test_random_traffic();
      test_extreme_deltas();
      drain();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #1500000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[three_axis_step_interpolator.f]
rtl/core/tasi_pkg.sv
rtl/core/tasi_lane.sv
rtl/core/tasi_seq.sv
rtl/core/tasi_skid.sv
rtl/core/three_axis_step_interpolator.sv
rtl/core/tasi_checker.sv
verif/tb_top.sv
